/* src/lps_pkg.sv */
// ----------------------------------------------------------------------------
// lps_pkg
// Shared types and constants for the line pixel stepper.
// ----------------------------------------------------------------------------
`default_nettype none

package lps_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int PIX_BITS       = 16;
    localparam int COLOR_BITS     = 32;
    localparam int DIM_BITS       = 13;
    localparam int CFG_ADDR_BITS  = 1;
    localparam int KIND_BITS      = 2;

    localparam logic [DIM_BITS-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [DIM_BITS-1:0] FRAME_HEIGHT_RST = 13'd480;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
    localparam logic [7:0] ALPHA_CLEAR  = 8'd0;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_NONE   = 2'd0,
        KIND_DIRECT = 2'd1,
        KIND_BLEND  = 2'd2
    } write_kind_t;

endpackage

`default_nettype wire

/* src/line_pixel_stepper_top.sv */
// ----------------------------------------------------------------------------
// line_pixel_stepper_top
// Integer line rasteriser: a load word latches a line, each tick word
// emits the next pixel with its clip/alpha classification.
// ----------------------------------------------------------------------------
// A load word (s_req_type 0) latches start, end and colour and gives no
// output word. Each tick word (s_req_type 1) while a line is in progress
// gives one pixel word in the next cycle; ticks with no line in progress are
// absorbed. The end point is not drawn, and the final pixel carries m_last.
// One word is accepted every cycle as long as the output register is free
// or being drained; the stepping add, compare and conditional subtract on
// the error term all complete in that cycle, so throughput is one pixel
// per clock.
`default_nettype none

module line_pixel_stepper_top
    import lps_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,

    input  wire logic                         cfg_wr_en,
    input  wire logic [CFG_ADDR_BITS-1:0]     cfg_addr,
    input  wire logic [DIM_BITS-1:0]          cfg_wdata,

    input  wire logic                         s_valid,
    output      logic                         s_ready,
    input  wire logic                         s_req_type,
    input  wire logic signed [COORD_BITS-1:0] s_start_x,
    input  wire logic signed [COORD_BITS-1:0] s_start_y,
    input  wire logic signed [COORD_BITS-1:0] s_end_x,
    input  wire logic signed [COORD_BITS-1:0] s_end_y,
    input  wire logic [COLOR_BITS-1:0]        s_line_color,

    output      logic                         m_valid,
    input  wire logic                         m_ready,
    output      logic signed [PIX_BITS-1:0]   m_pixel_x,
    output      logic signed [PIX_BITS-1:0]   m_pixel_y,
    output      logic [COLOR_BITS-1:0]        m_pixel_color,
    output      logic [KIND_BITS-1:0]         m_write_kind,
    output      logic                         m_last
);

    localparam int ERR_W = COORD_BITS + 3;
    localparam int DIF_W = COORD_BITS + 1;
    localparam int EXT_W = (COORD_BITS > PIX_BITS) ? COORD_BITS : PIX_BITS;
    localparam int CMP_W = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 1;

    logic [DIM_BITS-1:0]          frame_width_reg;
    logic [DIM_BITS-1:0]          frame_height_reg;

    logic                         active_reg,     active_next;
    logic signed [COORD_BITS-1:0] cur_x_reg,      cur_x_next;
    logic signed [COORD_BITS-1:0] cur_y_reg,      cur_y_next;
    logic signed [COORD_BITS-1:0] stop_reg,       stop_next;
    logic                         x_major_reg,    x_major_next;
    logic                         step_x_neg_reg, step_x_neg_next;
    logic                         step_y_neg_reg, step_y_neg_next;
    logic signed [ERR_W-1:0]      err_acc_reg,    err_acc_next;
    logic [DIF_W-1:0]             err_slope_reg,  err_slope_next;
    logic [DIF_W-1:0]             err_back_reg,   err_back_next;
    logic [COLOR_BITS-1:0]        color_reg,      color_next;

    logic                         m_valid_reg,    m_valid_next;
    logic signed [PIX_BITS-1:0]   m_x_reg,        m_x_next;
    logic signed [PIX_BITS-1:0]   m_y_reg,        m_y_next;
    logic [COLOR_BITS-1:0]        m_color_reg,    m_color_next;
    write_kind_t                  m_kind_reg,     m_kind_next;
    logic                         m_last_reg,     m_last_next;

    logic                         accept;
    logic signed [DIF_W-1:0]      dx_full, dy_full, dx_abs, dy_abs;
    logic [COORD_BITS-1:0]        dx_mag, dy_mag, dmajor, dminor;
    logic                         load_x_major;

    logic signed [ERR_W-1:0]      acc_sum;
    logic                         minor_step;
    logic signed [COORD_BITS-1:0] x_stepped, y_stepped, new_x, new_y;
    logic                         fin;
    logic signed [EXT_W-1:0]      px_ext, py_ext;
    logic signed [CMP_W-1:0]      px_cmp, py_cmp, w_cmp, h_cmp;
    logic                         clipped;
    logic [7:0]                   alpha;
    write_kind_t                  kind;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Line set-up
    assign dx_full = DIF_W'(s_end_x) - DIF_W'(s_start_x);
    assign dy_full = DIF_W'(s_end_y) - DIF_W'(s_start_y);
    assign dx_abs  = dx_full[DIF_W-1] ? -dx_full : dx_full;
    assign dy_abs  = dy_full[DIF_W-1] ? -dy_full : dy_full;
    assign dx_mag  = dx_abs[COORD_BITS-1:0];
    assign dy_mag  = dy_abs[COORD_BITS-1:0];
    assign load_x_major = dx_mag >= dy_mag;
    assign dmajor  = load_x_major ? dx_mag : dy_mag;
    assign dminor  = load_x_major ? dy_mag : dx_mag;

    // Pixel step
    assign acc_sum    = err_acc_reg + $signed({2'b00, err_slope_reg});
    assign minor_step = !acc_sum[ERR_W-1];
    assign x_stepped  = step_x_neg_reg ? cur_x_reg - COORD_BITS'(1) : cur_x_reg + COORD_BITS'(1);
    assign y_stepped  = step_y_neg_reg ? cur_y_reg - COORD_BITS'(1) : cur_y_reg + COORD_BITS'(1);
    assign new_x      = (x_major_reg || minor_step) ? x_stepped : cur_x_reg;
    assign new_y      = (!x_major_reg || minor_step) ? y_stepped : cur_y_reg;
    assign fin        = x_major_reg ? (new_x == stop_reg) : (new_y == stop_reg);

    // Clip and classify
    assign px_ext  = EXT_W'(cur_x_reg);
    assign py_ext  = EXT_W'(cur_y_reg);
    assign px_cmp  = CMP_W'(cur_x_reg);
    assign py_cmp  = CMP_W'(cur_y_reg);
    assign w_cmp   = $signed(CMP_W'(frame_width_reg));
    assign h_cmp   = $signed(CMP_W'(frame_height_reg));
    assign clipped = px_cmp[CMP_W-1] || py_cmp[CMP_W-1] || (px_cmp >= w_cmp) || (py_cmp >= h_cmp);
    assign alpha   = color_reg[COLOR_BITS-1 -: 8];

    always_comb begin
        if (clipped || alpha == ALPHA_OPAQUE) begin
            kind = KIND_NONE;
        end else if (alpha == ALPHA_CLEAR) begin
            kind = KIND_DIRECT;
        end else begin
            kind = KIND_BLEND;
        end
    end

    always_comb begin
        active_next     = active_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        stop_next       = stop_reg;
        x_major_next    = x_major_reg;
        step_x_neg_next = step_x_neg_reg;
        step_y_neg_next = step_y_neg_reg;
        err_acc_next    = err_acc_reg;
        err_slope_next  = err_slope_reg;
        err_back_next   = err_back_reg;
        color_next      = color_reg;

        m_valid_next = m_valid_reg && !m_ready;
        m_x_next     = m_x_reg;
        m_y_next     = m_y_reg;
        m_color_next = m_color_reg;
        m_kind_next  = m_kind_reg;
        m_last_next  = m_last_reg;

        if (accept) begin
            if (!s_req_type) begin
                color_next      = s_line_color;
                cur_x_next      = s_start_x;
                cur_y_next      = s_start_y;
                step_x_neg_next = dx_full[DIF_W-1] || (dx_full == '0);
                step_y_neg_next = dy_full[DIF_W-1] || (dy_full == '0);
                x_major_next    = load_x_major;
                err_slope_next  = {dminor, 1'b0};
                err_back_next   = {dmajor, 1'b0};
                err_acc_next    = -$signed(ERR_W'(dmajor));
                stop_next       = load_x_major ? s_end_x : s_end_y;
                active_next     = (dmajor != '0);
            end else if (active_reg) begin
                cur_x_next   = new_x;
                cur_y_next   = new_y;
                err_acc_next = minor_step ? acc_sum - $signed({2'b00, err_back_reg}) : acc_sum;
                active_next  = !fin;

                m_valid_next = 1'b1;
                m_x_next     = px_ext[PIX_BITS-1:0];
                m_y_next     = py_ext[PIX_BITS-1:0];
                m_color_next = color_reg;
                m_kind_next  = kind;
                m_last_next  = fin;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg  <= active_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_x_reg      <= cur_x_next;
        cur_y_reg      <= cur_y_next;
        stop_reg       <= stop_next;
        x_major_reg    <= x_major_next;
        step_x_neg_reg <= step_x_neg_next;
        step_y_neg_reg <= step_y_neg_next;
        err_acc_reg    <= err_acc_next;
        err_slope_reg  <= err_slope_next;
        err_back_reg   <= err_back_next;
        color_reg      <= color_next;
        m_x_reg        <= m_x_next;
        m_y_reg        <= m_y_next;
        m_color_reg    <= m_color_next;
        m_kind_reg     <= m_kind_next;
        m_last_reg     <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_x     = m_x_reg;
    assign m_pixel_y     = m_y_reg;
    assign m_pixel_color = m_color_reg;
    assign m_write_kind  = m_kind_reg;
    assign m_last        = m_last_reg;

endmodule

`default_nettype wire
